/* sv/adll_pkg.sv */
// Shared constants for the array-based doubly linked list.
// Field widths, command and status codes and the default pool size; no dependencies.
package adll_pkg;

  localparam int SlotsDefault = 32;

  localparam int CMD_W   = 1;
  localparam int KEY_W   = 31;
  localparam int STAT_W  = 2;
  localparam int SLOT_W  = 5;
  localparam int COUNT_W = 6;

  localparam logic [CMD_W-1:0] CMD_INSERT = 1'b0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 1'b1;

  localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STAT_W-1:0] ST_DELETED  = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

endpackage

/* sv/array_doubly_linked_list.sv */
// Array-based doubly linked list of keys in a pool of SLOTS slots.
// Depends on adll_pkg for field widths, command and status codes.
//
//   channel | handshake          | fields
//   --------+--------------------+---------------------
//   in      | in_valid, in_stall | command, key
//   out     | out_valid, out_stall | status, slot, count
//
// Insert: lowest-free-slot scan over the occupancy memory (one slot a cycle),
// then a walk along next links to the tail (one node a cycle). Delete: a
// walk along next links reading key and links of one node a cycle, then an
// unlink step. Output stalls hold the finished item in its done state.
// After rst a clearing pass writes every slot of the occupancy memory,
// with in_stall high. A stalled result sits in the output register while
// the next beat is taken and worked on; it is replaced only once taken.
module array_doubly_linked_list #(
  parameter int SLOTS = adll_pkg::SlotsDefault
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [adll_pkg::CMD_W-1:0]   command,
  input  logic [adll_pkg::KEY_W-1:0]   key,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [adll_pkg::STAT_W-1:0]  status,
  output logic [adll_pkg::SLOT_W-1:0]  slot,
  output logic [adll_pkg::COUNT_W-1:0] count
);
  import adll_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam int LW = SW + 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [LW-1:0] NIL_LINK  = {1'b1, {SW{1'b0}}};
  localparam logic [SW:0]   SLOTS_CNT = (SW + 1)'(SLOTS);
  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_ISET  = 4'd3;
  localparam logic [3:0] S_IWALK = 4'd4;
  localparam logic [3:0] S_DWALK = 4'd5;
  localparam logic [3:0] S_DUNL  = 4'd6;
  localparam logic [3:0] S_DONE  = 4'd7;

  logic [3:0]        state;
  logic [KEY_W-1:0]  key_hold;
  logic [SW-1:0]     cur;
  logic [SW-1:0]     free_slot;
  logic [SW:0]       scan_idx;
  logic [SW-1:0]     chk_idx;
  logic              rd_vld;
  logic [SW:0]       steps;
  logic [LW-1:0]     head;
  logic [CW-1:0]     entry_count;
  logic [STAT_W-1:0] res_status;
  logic [SW-1:0]     res_slot;

  // pool memories
  logic [KEY_W-1:0] key_mem  [SLOTS];
  logic [LW-1:0]    next_mem [SLOTS];
  logic [LW-1:0]    prev_mem [SLOTS];
  logic             used_mem [SLOTS];

  logic [KEY_W-1:0] key_q;
  logic [LW-1:0]    next_q;
  logic [LW-1:0]    prev_q;
  logic             used_q;

  logic [SW-1:0]    link_raddr;
  logic             key_we;
  logic             next_we;
  logic [SW-1:0]    next_waddr;
  logic [LW-1:0]    next_wdata;
  logic             prev_we;
  logic [SW-1:0]    prev_waddr;
  logic [LW-1:0]    prev_wdata;
  logic             used_we;
  logic [SW-1:0]    used_waddr;
  logic             used_wdata;

  logic iwalk_end;
  logic dwalk_hit;
  logic dwalk_miss;
  logic out_free;

  assign in_stall   = (state != S_IDLE);
  assign iwalk_end  = next_q[SW] || (steps == SLOTS_CNT);
  assign dwalk_hit  = (key_q == key_hold);
  assign dwalk_miss = !dwalk_hit && (next_q[SW] || (steps == SLOTS_CNT));
  assign out_free   = !out_valid || !out_stall;

  // one read address serves key, next and prev memories
  always_comb begin
    unique case (state)
      S_IDLE, S_ISET: link_raddr = head[SW-1:0];
      S_IWALK:        link_raddr = next_q[SW-1:0];
      // on a hit, reread the matching node so its links reach the unlink cycle
      S_DWALK:        link_raddr = dwalk_hit ? cur : next_q[SW-1:0];
      default:        link_raddr = cur;
    endcase
  end

  always_comb begin
    key_we     = 1'b0;
    next_we    = 1'b0;
    next_waddr = free_slot;
    next_wdata = NIL_LINK;
    prev_we    = 1'b0;
    prev_waddr = free_slot;
    prev_wdata = NIL_LINK;
    used_we    = 1'b0;
    used_waddr = free_slot;
    used_wdata = 1'b1;
    unique case (state)
      S_CLR: begin
        used_we    = 1'b1;
        used_waddr = scan_idx[SW-1:0];
        used_wdata = 1'b0;
      end
      S_ISET: begin
        key_we  = 1'b1;
        next_we = 1'b1;
        used_we = 1'b1;
        prev_we = head[SW];
      end
      S_IWALK: begin
        if (iwalk_end) begin
          next_we    = 1'b1;
          next_waddr = cur;
          next_wdata = {1'b0, free_slot};
          prev_we    = 1'b1;
          prev_wdata = {1'b0, cur};
        end
      end
      S_DUNL: begin
        // bypass the node: predecessor's next and successor's prev
        next_we    = !prev_q[SW];
        next_waddr = prev_q[SW-1:0];
        next_wdata = next_q;
        prev_we    = !next_q[SW];
        prev_waddr = next_q[SW-1:0];
        prev_wdata = prev_q;
        used_we    = 1'b1;
        used_waddr = cur;
        used_wdata = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (key_we) key_mem[free_slot] <= key_hold;
    key_q <= key_mem[link_raddr];
  end

  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_waddr] <= next_wdata;
    next_q <= next_mem[link_raddr];
  end

  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_waddr] <= prev_wdata;
    prev_q <= prev_mem[link_raddr];
  end

  always_ff @(posedge clk) begin
    if (used_we) used_mem[used_waddr] <= used_wdata;
    used_q <= used_mem[scan_idx[SW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLR;
      scan_idx    <= '0;
      head        <= NIL_LINK;
      entry_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_CLR: begin
          scan_idx <= scan_idx + 1'b1;
          if (scan_idx[SW-1:0] == LAST_SLOT) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            key_hold <= key;
            scan_idx <= '0;
            rd_vld   <= 1'b0;
            cur      <= head[SW-1:0];
            steps    <= '0;
            if (command == CMD_INSERT) begin
              state <= S_SCAN;
            end else if (head[SW]) begin
              res_status <= ST_NOTFOUND;
              res_slot   <= '0;
              state      <= S_DONE;
            end else begin
              state <= S_DWALK;
            end
          end
        end
        S_SCAN: begin
          // each read is registered in used_q before its slot is checked
          if (rd_vld && !used_q) begin
            free_slot <= chk_idx;
            state     <= S_ISET;
          end else if (rd_vld && (chk_idx == LAST_SLOT)) begin
            res_status <= ST_FULL;
            res_slot   <= '0;
            state      <= S_DONE;
          end else begin
            chk_idx  <= scan_idx[SW-1:0];
            scan_idx <= scan_idx + 1'b1;
            rd_vld   <= 1'b1;
          end
        end
        S_ISET: begin
          res_status <= ST_INSERTED;
          res_slot   <= free_slot;
          cur        <= head[SW-1:0];
          steps      <= '0;
          if (head[SW]) begin
            head        <= {1'b0, free_slot};
            entry_count <= entry_count + 1'b1;
            state       <= S_DONE;
          end else begin
            state <= S_IWALK;
          end
        end
        S_IWALK: begin
          if (iwalk_end) begin
            entry_count <= entry_count + 1'b1;
            state       <= S_DONE;
          end else begin
            cur   <= next_q[SW-1:0];
            steps <= steps + 1'b1;
          end
        end
        S_DWALK: begin
          if (dwalk_hit) begin
            state <= S_DUNL;
          end else if (dwalk_miss) begin
            res_status <= ST_NOTFOUND;
            res_slot   <= '0;
            state      <= S_DONE;
          end else begin
            cur   <= next_q[SW-1:0];
            steps <= steps + 1'b1;
          end
        end
        S_DUNL: begin
          if (prev_q[SW]) head <= next_q;
          if (entry_count != '0) entry_count <= entry_count - 1'b1;
          res_status <= ST_DELETED;
          res_slot   <= cur;
          state      <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free or being taken
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      status <= res_status;
      slot   <= SLOT_W'(res_slot);
      count  <= COUNT_W'(entry_count);
    end
  end

  a_head_matches_count: assert property (@(posedge clk) disable iff (rst)
    head[SW] == (entry_count == '0))
    else $error("head marker disagrees with entry count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(SLOTS))
    else $error("entry count exceeds pool size");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && res_status == ST_FULL) |-> entry_count == CW'(SLOTS))
    else $error("full reported with free slots");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid)) |-> $past(state) == S_DONE)
    else $error("result appeared without a finished item");

endmodule

/* tb/array_doubly_linked_list_tb.sv */
// Testbench for array_doubly_linked_list: a list tracker class predicts each result
// and checks it; a task drives the input channel, a process the output stall. Depends on adll_pkg.
import adll_pkg::*;

typedef struct packed {
  logic [STAT_W-1:0]  status;
  logic [SLOT_W-1:0]  slot;
  logic [COUNT_W-1:0] count;
} list_result_t;

class list_tracker;
  localparam int NO_SLOT = -1;

  logic [KEY_W-1:0] key_at[SlotsDefault];
  int               next_of[SlotsDefault];
  int               prev_of[SlotsDefault];
  bit               taken[SlotsDefault];
  int               head;
  int               entries;
  list_result_t     due_results[$];
  int               mismatches;
  int               results_seen;

  function new();
    for (int i = 0; i < SlotsDefault; i++) begin
      key_at[i]  = '0;
      next_of[i] = NO_SLOT;
      prev_of[i] = NO_SLOT;
      taken[i]   = 1'b0;
    end
    head         = NO_SLOT;
    entries      = 0;
    mismatches   = 0;
    results_seen = 0;
  endfunction

  function void push(logic [STAT_W-1:0] st, int sl);
    list_result_t r;
    r.status = st;
    r.slot   = SLOT_W'(sl);
    r.count  = COUNT_W'(entries);
    due_results.push_back(r);
  endfunction

  function void append_key(logic [KEY_W-1:0] k);
    int free_idx;
    int cur;
    int steps;
    free_idx = NO_SLOT;
    for (int i = 0; i < SlotsDefault; i++) begin
      if (!taken[i]) begin
        free_idx = i;
        break;
      end
    end
    if (free_idx == NO_SLOT) begin
      push(ST_FULL, 0);
      return;
    end
    key_at[free_idx]  = k;
    next_of[free_idx] = NO_SLOT;
    taken[free_idx]   = 1'b1;
    if (head == NO_SLOT) begin
      head = free_idx;
      prev_of[free_idx] = NO_SLOT;
    end else begin
      cur = head;
      steps = 0;
      while (next_of[cur] != NO_SLOT && steps < SlotsDefault) begin
        cur = next_of[cur];
        steps++;
      end
      next_of[cur] = free_idx;
      prev_of[free_idx] = cur;
    end
    entries++;
    push(ST_INSERTED, free_idx);
  endfunction

  function void unlink_key(logic [KEY_W-1:0] k);
    int cur;
    int steps;
    int pred;
    int succ;
    cur = head;
    steps = 0;
    while (cur != NO_SLOT && steps < SlotsDefault) begin
      if (key_at[cur] == k) break;
      cur = next_of[cur];
      steps++;
    end
    if (cur == NO_SLOT || key_at[cur] != k) begin
      push(ST_NOTFOUND, 0);
      return;
    end
    pred = prev_of[cur];
    succ = next_of[cur];
    if (pred != NO_SLOT) next_of[pred] = succ;
    else head = succ;
    if (succ != NO_SLOT) prev_of[succ] = pred;
    next_of[cur] = NO_SLOT;
    prev_of[cur] = NO_SLOT;
    taken[cur]   = 1'b0;
    if (entries > 0) entries--;
    push(ST_DELETED, cur);
  endfunction

  // Note one accepted input beat and queue the result it must cause.
  function void take_command(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] k);
    if (cmd == CMD_INSERT) append_key(k);
    else unlink_key(k);
  endfunction

  // Key of a random node now in the list; a small key when the list is empty.
  function logic [KEY_W-1:0] stored_key();
    int cur;
    int hops;
    if (entries == 0) return KEY_W'($urandom_range(1, 15));
    hops = $urandom_range(0, entries - 1);
    cur = head;
    for (int i = 0; i < hops && next_of[cur] != NO_SLOT; i++) cur = next_of[cur];
    return key_at[cur];
  endfunction

  function int pending();
    return due_results.size();
  endfunction

  task report(string msg);
    mismatches++;
    if (mismatches <= 40) $display("mismatch at result %0d: %s", results_seen, msg);
  endtask

  task check_result(logic [STAT_W-1:0] st, logic [SLOT_W-1:0] sl, logic [COUNT_W-1:0] cn);
    list_result_t want;
    results_seen++;
    if (due_results.size() == 0) begin
      report($sformatf("unexpected beat status=%0d slot=%0d count=%0d", st, sl, cn));
      return;
    end
    want = due_results.pop_front();
    if (st !== want.status)
      report($sformatf("status %0d, want %0d", st, want.status));
    if (sl !== want.slot)
      report($sformatf("slot %0d, want %0d", sl, want.slot));
    if (cn !== want.count)
      report($sformatf("count %0d, want %0d", cn, want.count));
  endtask
endclass

module array_doubly_linked_list_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 4000;
  localparam int TAIL_WAIT  = 2 * SlotsDefault + 8;

  logic                clk;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [CMD_W-1:0]    command = CMD_INSERT;
  logic [KEY_W-1:0]    key = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STAT_W-1:0]   status;
  logic [SLOT_W-1:0]   slot;
  logic [COUNT_W-1:0]  count;

  list_tracker tracker;
  bit          sender_calm = 1'b0;
  int          idle_cycles = 0;

  array_doubly_linked_list dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .key       (key),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .slot      (slot),
    .count     (count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Half no gap, most of the rest short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 9) < 4) return KEY_W'($urandom_range(0, 15));
    return KEY_W'($urandom());
  endfunction

  task automatic send_beat(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] k);
    int gap;
    gap = sender_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    key      <= k;
    do @(posedge clk); while (in_stall);
    tracker.take_command(cmd, k);
  endtask

  task automatic run_directed();
    send_beat(CMD_DELETE, 31'd5);          // delete on an empty list
    send_beat(CMD_INSERT, 31'd0);          // key zero
    send_beat(CMD_INSERT, 31'h7FFF_FFFF);
    send_beat(CMD_INSERT, 31'd1);
    send_beat(CMD_INSERT, 31'h2AAA_AAAA);
    send_beat(CMD_INSERT, 31'h5555_5555);
    send_beat(CMD_INSERT, 31'd1);          // duplicate key
    send_beat(CMD_DELETE, 31'd1);          // nearest the head goes first
    send_beat(CMD_DELETE, 31'd0);          // head node
    send_beat(CMD_DELETE, 31'd1);          // tail node
    send_beat(CMD_DELETE, 31'd1);          // no longer present
    send_beat(CMD_INSERT, 31'd9);          // reuse of the lowest freed slot
    send_beat(CMD_INSERT, 31'd3);
    send_beat(CMD_DELETE, 31'h2AAA_AAAA);
    send_beat(CMD_DELETE, 31'h7FFF_FFFF);
    send_beat(CMD_DELETE, 31'h5555_5555);
    send_beat(CMD_DELETE, 31'd9);
    send_beat(CMD_DELETE, 31'd3);
    send_beat(CMD_DELETE, 31'd3);
    send_beat(CMD_INSERT, 31'd0);
  endtask

  // Segments lean toward filling, draining or a mix; deletes mostly hit stored keys.
  task automatic run_random(int n_items);
    int done;
    int mode;
    int seg_len;
    int ins_pct;
    int r;
    done = 0;
    mode = 0;
    seg_len = 45;
    while (done < n_items) begin
      case (mode)
        0:       ins_pct = 95;
        1:       ins_pct = 10;
        2:       ins_pct = 50;
        default: ins_pct = 65;
      endcase
      for (int i = 0; i < seg_len && done < n_items; i++) begin
        if ($urandom_range(0, 99) < ins_pct) begin
          send_beat(CMD_INSERT, pick_key());
        end else begin
          r = $urandom_range(0, 99);
          if (r < 70) send_beat(CMD_DELETE, tracker.stored_key());
          else send_beat(CMD_DELETE, pick_key());
        end
        done++;
      end
      mode = $urandom_range(0, 3);
      seg_len = $urandom_range(20, 60);
      sender_calm = ($urandom_range(0, 4) == 0);
    end
  endtask

  initial begin
    int stall_len;
    int open_len;
    forever begin
      stall_len = pick_gap();
      open_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250) : $urandom_range(1, 8);
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat (open_len) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      tracker.check_result(status, slot, count);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    tracker = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_random(700);
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

/* filelist.f */
sv/adll_pkg.sv
sv/array_doubly_linked_list.sv
tb/array_doubly_linked_list_tb.sv
